/* hdl/periodic_jitter_histogram_defines.svh */
// Assertion macros used by the jitter histogram design file.
`ifndef PERIODIC_JITTER_HISTOGRAM_DEFINES_SVH
`define PERIODIC_JITTER_HISTOGRAM_DEFINES_SVH
`ifndef ASSERT_OFF
`define PJH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PJH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PJH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PJH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/pjh_pkg.sv */
// Types and constants of the periodic jitter histogram.
package pjh_pkg;

   localparam int unsigned TS_W     = 32;
   localparam int unsigned JIT_W    = 30;
   localparam int unsigned CNT_W    = 32;
   localparam int unsigned IDX_W    = 6;
   localparam int unsigned CSR_IX_W = 2;

   localparam logic [CSR_IX_W-1:0] REG_PERIOD_CH0 = 2'd0;
   localparam logic [CSR_IX_W-1:0] REG_PERIOD_CH1 = 2'd1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic [TS_W-1:0] PERIOD_RESET = 32'd80000;
   localparam logic [TS_W:0]   ROUND_ADD    = 33'd4;
   localparam int unsigned     SCALE_SHIFT  = 3;

   typedef struct packed {
      logic meas;
      logic rd;
   } item_flags_type;

endpackage

/* hdl/periodic_jitter_histogram.sv */
// Two-channel jitter monitor with per-channel histograms held in one memory.
//
//  Channel  Direction  Handshake          Payload
//  req      in         req_valid/stall    kind, channel, timestamp, bin_index
//  rsp      out        rsp_valid/stall    measured, jitter, max_jitter, bin_count
//  csr      in         csr_wr_en          csr_index, csr_wdata
//
// One word is accepted per cycle unless req_stall is high, then passes stages a, b, c to rsp.
// The histogram memory is read one stage before it is written back, with one forwarding
// register covering back-to-back updates of the same bin.
// After reset a clearing pass zeroes all NUM_CHANNELS * NUM_BINS entries of the memory,
// one entry per cycle; requests are stalled during that pass.
// A stalled result holds the whole pipeline and stalls the request side.
module periodic_jitter_histogram #(
   parameter int unsigned NUM_BINS     = 64,
   parameter int unsigned NUM_CHANNELS = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [pjh_pkg::CSR_IX_W-1:0]       csr_index,
   input  logic [pjh_pkg::TS_W-1:0]           csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic                               req_channel,
   input  logic [pjh_pkg::TS_W-1:0]           req_timestamp,
   input  logic [pjh_pkg::IDX_W-1:0]          req_bin_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_measured,
   output logic [pjh_pkg::JIT_W-1:0]          rsp_jitter,
   output logic [pjh_pkg::JIT_W-1:0]          rsp_max_jitter,
   output logic [pjh_pkg::CNT_W-1:0]          rsp_bin_count
);

   `include "periodic_jitter_histogram_defines.svh"

   localparam int unsigned DEPTH = NUM_CHANNELS * NUM_BINS;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned BW    = $clog2(NUM_BINS);
   localparam int unsigned CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam int unsigned TS_W  = pjh_pkg::TS_W;
   localparam int unsigned JIT_W = pjh_pkg::JIT_W;
   localparam int unsigned CNT_W = pjh_pkg::CNT_W;

   logic [TS_W-1:0]  period0_ff, period1_ff;
   logic [TS_W-1:0]  prev_time_ff [NUM_CHANNELS];

   logic             clr_busy_ff;
   logic [AW-1:0]    clr_addr_ff;

   logic                     a_valid_ff, b_valid_ff, c_valid_ff;
   pjh_pkg::item_flags_type  a_flags_ff, b_flags_ff, c_flags_ff;
   logic [TS_W-1:0]          a_interval_ff, a_period_ff, b_dev_ff;
   logic [CW-1:0]            a_ch_ff, b_ch_ff;
   logic [pjh_pkg::IDX_W-1:0] a_bin_index_ff, b_bin_index_ff;
   logic [JIT_W-1:0]         c_jit_ff;
   logic [AW-1:0]            c_addr_ff;

   logic [CNT_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0] rd_ff;
   logic             fwd_valid_ff;
   logic [AW-1:0]    fwd_addr_ff;
   logic [CNT_W-1:0] fwd_data_ff;

   logic [JIT_W-1:0] largest_ff;

   logic             rsp_valid_ff, rsp_measured_ff;
   logic [JIT_W-1:0] rsp_jitter_ff, rsp_max_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   logic                    adv, req_acc, ch_ok;
   logic [CW-1:0]           ch_idx;
   logic [TS_W-1:0]         prev_sel, period_sel;
   pjh_pkg::item_flags_type flags_in;
   logic [TS_W:0]           jit_sum;
   logic [JIT_W-1:0]        b_jit;
   logic [BW-1:0]           b_bin;
   logic [AW-1:0]           b_addr;
   logic [CNT_W-1:0]        base_cnt, count_in;
   logic [JIT_W-1:0]        largest_in;
   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   logic [CNT_W-1:0]        mem_wd;

   // Front stage: previous time, period and item classification.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clr_busy_ff || !adv;
   assign req_acc   = req_valid && !req_stall;
   assign ch_ok     = 32'(req_channel) < 32'(NUM_CHANNELS);
   assign ch_idx    = ch_ok ? CW'(req_channel) : '0;
   assign prev_sel  = prev_time_ff[ch_idx];
   assign period_sel = (req_channel == 1'b0) ? period0_ff : period1_ff;

   always_comb begin
      flags_in.meas = ch_ok && (req_kind == pjh_pkg::KIND_SAMPLE) && (prev_sel != '0);
      flags_in.rd   = ch_ok && (req_kind == pjh_pkg::KIND_READ)
                      && (32'(req_bin_index) < 32'(NUM_BINS));
   end

   // Middle stage: rounded jitter, bin clamp and histogram address.
   assign jit_sum = {1'b0, b_dev_ff} + pjh_pkg::ROUND_ADD;
   assign b_jit   = jit_sum[pjh_pkg::SCALE_SHIFT +: JIT_W];

   always_comb begin
      if (b_flags_ff.meas) begin
         if (32'(b_jit) >= 32'(NUM_BINS)) begin
            b_bin = BW'(NUM_BINS - 1);
         end else begin
            b_bin = b_jit[BW-1:0];
         end
      end else begin
         b_bin = BW'(b_bin_index_ff);
      end
      b_addr = AW'(AW'(b_ch_ff) * AW'(NUM_BINS)) + AW'(b_bin);
   end

   // Last stage: forwarded count, increment and running maximum.
   always_comb begin
      base_cnt = (fwd_valid_ff && (fwd_addr_ff == c_addr_ff)) ? fwd_data_ff : rd_ff;
      if (c_flags_ff.meas) begin
         count_in = base_cnt + CNT_W'(1);
      end else if (c_flags_ff.rd) begin
         count_in = base_cnt;
      end else begin
         count_in = '0;
      end
      largest_in = (c_flags_ff.meas && (c_jit_ff > largest_ff)) ? c_jit_ff : largest_ff;
      mem_we = clr_busy_ff || (adv && c_valid_ff && c_flags_ff.meas);
      mem_wa = clr_busy_ff ? clr_addr_ff : c_addr_ff;
      mem_wd = clr_busy_ff ? '0 : count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period0_ff   <= pjh_pkg::PERIOD_RESET;
         period1_ff   <= pjh_pkg::PERIOD_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            prev_time_ff[i] <= '0;
         end
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               pjh_pkg::REG_PERIOD_CH0: period0_ff <= csr_wdata;
               pjh_pkg::REG_PERIOD_CH1: period1_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (req_acc && ch_ok && (req_kind == pjh_pkg::KIND_SAMPLE)) begin
            prev_time_ff[ch_idx] <= req_timestamp;
         end
         if (adv) begin
            a_valid_ff   <= req_acc;
            b_valid_ff   <= a_valid_ff;
            c_valid_ff   <= b_valid_ff;
            fwd_valid_ff <= c_valid_ff && c_flags_ff.meas;
            rsp_valid_ff <= c_valid_ff;
            if (c_valid_ff) begin
               largest_ff <= largest_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_flags_ff     <= flags_in;
         a_interval_ff  <= req_timestamp - prev_sel;
         a_period_ff    <= period_sel;
         a_ch_ff        <= ch_idx;
         a_bin_index_ff <= req_bin_index;

         b_flags_ff     <= a_flags_ff;
         b_dev_ff       <= (a_interval_ff >= a_period_ff) ? (a_interval_ff - a_period_ff)
                                                          : (a_period_ff - a_interval_ff);
         b_ch_ff        <= a_ch_ff;
         b_bin_index_ff <= a_bin_index_ff;

         c_flags_ff     <= b_flags_ff;
         c_jit_ff       <= b_jit;
         c_addr_ff      <= b_addr;

         fwd_addr_ff    <= c_addr_ff;
         fwd_data_ff    <= count_in;

         rsp_measured_ff <= c_flags_ff.meas;
         rsp_jitter_ff   <= c_flags_ff.meas ? c_jit_ff : '0;
         rsp_max_ff      <= largest_in;
         rsp_count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (adv) begin
         rd_ff <= mem[b_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_measured   = rsp_measured_ff;
   assign rsp_jitter     = rsp_jitter_ff;
   assign rsp_max_jitter = rsp_max_ff;
   assign rsp_bin_count  = rsp_count_ff;

   `PJH_ASSERT_IMPLY(a_clear_stalls, clock, reset, clr_busy_ff, req_stall)
   `PJH_ASSERT_NEXT(a_clear_done_stays, clock, reset, !clr_busy_ff, !clr_busy_ff)
   `PJH_ASSERT_NEXT(a_max_monotonic, clock, reset, 1'b1, largest_ff >= $past(largest_ff))
   `PJH_ASSERT_IMPLY(a_jitter_within_max, clock, reset, rsp_valid_ff && rsp_measured_ff,
                     rsp_jitter_ff <= rsp_max_ff)
   `PJH_ASSERT_IMPLY(a_no_items_while_clearing, clock, reset, clr_busy_ff,
                     !a_valid_ff && !b_valid_ff && !c_valid_ff)

endmodule
